// ===== hw/rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, constants and types for the shortest-path unit.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int NODE_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int WEIGHT_W    = 14;
    localparam int DIST_W      = 18;

    // Default store size and the hard limit set by the four-bit node fields.
    localparam int MAX_NODES_DEF = 16;
    localparam int NODE_LIMIT    = 16;

    localparam logic [WEIGHT_W-1:0] NO_EDGE  = 14'd9999;
    localparam logic [DIST_W-1:0]   DIST_MAX = '1;
    localparam logic [COUNT_W-1:0]  COUNT_RESET = 5'd16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Outcome of relaxing one edge and offering its end node for selection.
    typedef struct packed {
        logic              write_en;
        logic [DIST_W-1:0] dist_val;
        logic              take;
    } relax_res_t;

endpackage

// ===== hw/rtl/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// ssp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssp_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ssp_relax.sv =====
// ----------------------------------------------------------------------------
// ssp_relax
// Edge relaxation with saturation, and the running least-distance compare.
// ----------------------------------------------------------------------------
module ssp_relax
    import ssp_pkg::*;
(
    input  logic [DIST_W-1:0]   cur_dist,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [DIST_W-1:0]   old_dist,
    input  logic                visited,
    input  logic                reached,
    input  logic                found,
    input  logic [DIST_W-1:0]   best_dist,
    output relax_res_t          res
);

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] cand;
    logic              new_reached;
    logic [DIST_W-1:0] new_dist;

    always_comb
    begin
        sum  = {1'b0, cur_dist} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, weight};
        cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

        res.write_en = !visited && (weight < NO_EDGE) && (!reached || cand < old_dist);
        new_reached  = reached || res.write_en;
        new_dist     = res.write_en ? cand : old_dist;

        // A node joins the next selection only if it is still open and reached.
        res.dist_val = new_dist;
        res.take     = !visited && new_reached && (!found || new_dist < best_dist);
    end

endmodule

// ===== hw/rtl/single_source_shortest_path_unit.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit
// Dijkstra shortest paths over an adjacency-matrix weight store.
// ----------------------------------------------------------------------------
// A load transfer (command 0) writes one edge weight into the matrix store;
// a weight of 9999 or more means no edge, and loads outside the store are
// dropped. A run transfer (command 1) computes the distance from the source
// to each of the n active nodes (n from node_count, zero acting as one) and
// then delivers n result transfers in node order, the final one with last
// set. During a run each visited node costs one relaxation pass over its
// edge row, because the edge row and the distance table are each read
// through a single memory port, one entry per cycle; each result is then
// read back from the distance table before it is delivered. The unit
// takes no new item while a run is busy, but a waiting final result does
// not hold up the next item. Edge entries that a run reads must have been
// loaded first.
// ----------------------------------------------------------------------------
module single_source_shortest_path_unit
    import ssp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [NODE_W-1:0]   row,
    input  logic [NODE_W-1:0]   col,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [NODE_W-1:0]   source,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [NODE_W-1:0]   node,
    output logic [DIST_W-1:0]   distance,
    output logic                reachable,
    output logic                last
);

    // Only the first sixteen nodes can take part in a run.
    localparam int ACT_NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
    localparam int IDX_W     = $clog2(ACT_NODES);
    localparam int EDEPTH    = MAX_NODES * MAX_NODES;
    localparam int EADDR_W   = $clog2(EDEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RELAX = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0]           state_reg,     state_next;
    logic [COUNT_W-1:0]   node_count_reg, node_count_next;
    logic [IDX_W-1:0]     cur_reg,       cur_next;
    logic [DIST_W-1:0]    cur_dist_reg,  cur_dist_next;
    logic [COUNT_W-1:0]   rd_cnt_reg,    rd_cnt_next;
    logic                 pend_reg,      pend_next;
    logic [IDX_W-1:0]     pend_idx_reg,  pend_idx_next;
    logic                 found_reg,     found_next;
    logic [IDX_W-1:0]     best_idx_reg,  best_idx_next;
    logic [DIST_W-1:0]    best_dist_reg, best_dist_next;
    logic [ACT_NODES-1:0] visited_reg,   visited_next;
    logic [ACT_NODES-1:0] reached_reg,   reached_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]    node_reg,      node_next;
    logic [DIST_W-1:0]    distance_reg,  distance_next;
    logic                 reachable_reg, reachable_next;
    logic                 last_reg,      last_next;

    logic [COUNT_W-1:0]   active_n;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     src_idx;
    logic                 load_ok;

    logic                 edge_we;
    logic [EADDR_W-1:0]   edge_waddr;
    logic                 edge_re;
    logic [EADDR_W-1:0]   edge_raddr;
    logic [WEIGHT_W-1:0]  edge_rdata;

    logic                 dist_we;
    logic [IDX_W-1:0]     dist_waddr;
    logic [DIST_W-1:0]    dist_wdata;
    logic                 dist_re;
    logic [DIST_W-1:0]    dist_rdata;

    relax_res_t           relax;

    // Row-major edge matrix, never cleared or checked; user loads entries before use.
    ssp_ram
    #(
        .WIDTH (WEIGHT_W),
        .DEPTH (EDEPTH),
        .AW    (EADDR_W)
    )
    u_edge_ram
    (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (edge_waddr),
        .wr_data (weight),
        .rd_en   (edge_re),
        .rd_addr (edge_raddr),
        .rd_data (edge_rdata)
    );

    // Best distance per node; an entry only counts while its reached bit is set.
    ssp_ram
    #(
        .WIDTH (DIST_W),
        .DEPTH (ACT_NODES),
        .AW    (IDX_W)
    )
    u_dist_ram
    (
        .clk     (clk),
        .wr_en   (dist_we),
        .wr_addr (dist_waddr),
        .wr_data (dist_wdata),
        .rd_en   (dist_re),
        .rd_addr (rd_idx),
        .rd_data (dist_rdata)
    );

    ssp_relax u_relax
    (
        .cur_dist  (cur_dist_reg),
        .weight    (edge_rdata),
        .old_dist  (dist_rdata),
        .visited   (visited_reg[pend_idx_reg]),
        .reached   (reached_reg[pend_idx_reg]),
        .found     (found_reg),
        .best_dist (best_dist_reg),
        .res       (relax)
    );

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            active_n = COUNT_W'(1);
        end
        else if (node_count_reg > COUNT_W'(ACT_NODES))
        begin
            active_n = COUNT_W'(ACT_NODES);
        end
        else
        begin
            active_n = node_count_reg;
        end
    end

    assign rd_idx     = rd_cnt_reg[IDX_W-1:0];
    assign src_idx    = source[IDX_W-1:0];
    assign load_ok    = (32'(row) < MAX_NODES) && (32'(col) < MAX_NODES);
    assign edge_waddr = EADDR_W'(EADDR_W'(row) * EADDR_W'(MAX_NODES)) + EADDR_W'(col);
    assign edge_raddr = EADDR_W'(EADDR_W'(cur_reg) * EADDR_W'(MAX_NODES)) + EADDR_W'(rd_idx);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign node      = node_reg;
    assign distance  = distance_reg;
    assign reachable = reachable_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = cfg_valid ? cfg_data : node_count_reg;
        cur_next        = cur_reg;
        cur_dist_next   = cur_dist_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        visited_next    = visited_reg;
        reached_next    = reached_reg;
        out_valid_next  = out_valid_reg;
        node_next       = node_reg;
        distance_next   = distance_reg;
        reachable_next  = reachable_reg;
        last_next       = last_reg;

        edge_we    = 1'b0;
        edge_re    = 1'b0;
        dist_we    = 1'b0;
        dist_waddr = '0;
        dist_wdata = '0;
        dist_re    = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_LOAD)
                    begin
                        edge_we = load_ok;
                    end
                    else
                    begin
                        visited_next = '0;
                        reached_next = '0;
                        rd_cnt_next  = '0;
                        pend_next    = 1'b0;
                        found_next   = 1'b0;
                        if ({1'b0, source} < active_n)
                        begin
                            // The source is the first node selected, at distance zero.
                            reached_next[src_idx] = 1'b1;
                            visited_next[src_idx] = 1'b1;
                            cur_next              = src_idx;
                            cur_dist_next         = '0;
                            dist_we               = 1'b1;
                            dist_waddr            = src_idx;
                            state_next            = ST_RELAX;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            ST_RELAX:
            begin
                // Reads run one entry ahead of the write-back, so no entry is
                // read and written in the same pass at once.
                if (rd_cnt_reg < active_n)
                begin
                    edge_re       = 1'b1;
                    dist_re       = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx;
                    rd_cnt_next   = rd_cnt_reg + COUNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (relax.write_en)
                    begin
                        dist_we                    = 1'b1;
                        dist_waddr                 = pend_idx_reg;
                        dist_wdata                 = relax.dist_val;
                        reached_next[pend_idx_reg] = 1'b1;
                    end
                    if (relax.take)
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = pend_idx_reg;
                        best_dist_next = relax.dist_val;
                    end
                end
                else if (rd_cnt_reg == active_n)
                begin
                    rd_cnt_next = '0;
                    if (found_reg)
                    begin
                        cur_next                   = best_idx_reg;
                        cur_dist_next              = best_dist_reg;
                        visited_next[best_idx_reg] = 1'b1;
                        found_next                 = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_OUT:
            begin
                if (pend_reg)
                begin
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    node_next      = NODE_W'(pend_idx_reg);
                    reachable_next = reached_reg[pend_idx_reg];
                    distance_next  = reached_reg[pend_idx_reg] ? dist_rdata : DIST_MAX;
                    last_next      = (COUNT_W'(pend_idx_reg) + COUNT_W'(1)) == active_n;
                    if (last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if ((rd_cnt_reg < active_n) && (!out_valid_reg || out_ready))
                begin
                    dist_re       = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx;
                    rd_cnt_next   = rd_cnt_reg + COUNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= COUNT_RESET;
            cur_reg        <= '0;
            cur_dist_reg   <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            visited_reg    <= '0;
            reached_reg    <= '0;
            out_valid_reg  <= 1'b0;
            node_reg       <= '0;
            distance_reg   <= '0;
            reachable_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            cur_reg        <= cur_next;
            cur_dist_reg   <= cur_dist_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_dist_reg  <= best_dist_next;
            visited_reg    <= visited_next;
            reached_reg    <= reached_next;
            out_valid_reg  <= out_valid_next;
            node_reg       <= node_next;
            distance_reg   <= distance_next;
            reachable_reg  <= reachable_next;
            last_reg       <= last_next;
        end
    end

endmodule

// ===== verif/ssp_path_checker.sv =====
// ----------------------------------------------------------------------------
// ssp_path_checker
// Watches the shortest-path unit's channels and checks every node report.
// ----------------------------------------------------------------------------
// Keeps its own copy of the edge matrix and of node_count. Each accepted run
// transfer is solved here with a plain Dijkstra pass, and the resulting node
// reports are queued. Every output transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module ssp_path_checker
    import ssp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                command,
    input  logic [NODE_W-1:0]   row,
    input  logic [NODE_W-1:0]   col,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [NODE_W-1:0]   source,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [NODE_W-1:0]   node,
    input  logic [DIST_W-1:0]   distance,
    input  logic                reachable,
    input  logic                last,

    output int                  fail_count,
    output int                  outstanding,
    output int                  nodes_in_use,
    output int                  reports_checked
);

    localparam int REPORT_LIMIT = 10;
    localparam int NODE_SPAN    = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              last;
    } node_report_t;

    logic [WEIGHT_W-1:0] edge_store [MAX_NODES][MAX_NODES];
    logic [COUNT_W-1:0]  node_count_q;
    node_report_t        pending_reports [$];

    function automatic int active_count(input logic [COUNT_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > NODE_SPAN)
            return NODE_SPAN;
        return int'(value);
    endfunction

    // Solves one run from src and queues one report per active node.
    task automatic predict_distances(input logic [NODE_W-1:0] src);
        logic [DIST_W-1:0]   path_len [NODE_SPAN];
        bit                  reached [NODE_SPAN];
        bit                  settled [NODE_SPAN];
        logic [DIST_W:0]     cand;
        logic [WEIGHT_W-1:0] w;
        node_report_t        rep;
        int                  n;
        int                  cur;
        int                  i;
        int                  round;
        bit                  found;
        n = active_count(node_count_q);
        for (i = 0; i < NODE_SPAN; i++)
        begin
            path_len[i] = DIST_MAX;
            reached[i]  = 1'b0;
            settled[i]  = 1'b0;
        end
        if (int'(src) < n)
        begin
            reached[src]  = 1'b1;
            path_len[src] = '0;
            for (round = 0; round < n; round++)
            begin
                found = 1'b0;
                cur   = 0;
                // Strict less-than keeps the lowest-numbered node on a tie.
                for (i = 0; i < n; i++)
                begin
                    if (!settled[i] && reached[i] && (!found || path_len[i] < path_len[cur]))
                    begin
                        cur   = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    break;
                settled[cur] = 1'b1;
                for (i = 0; i < n; i++)
                begin
                    w = edge_store[cur][i];
                    if (!settled[i] && w < NO_EDGE)
                    begin
                        cand = path_len[cur] + w;
                        if (cand > DIST_MAX)
                            cand = DIST_MAX;
                        if (!reached[i] || cand[DIST_W-1:0] < path_len[i])
                        begin
                            path_len[i] = cand[DIST_W-1:0];
                            reached[i]  = 1'b1;
                        end
                    end
                end
            end
        end
        for (i = 0; i < n; i++)
        begin
            rep.node        = NODE_W'(i);
            rep.distance    = reached[i] ? path_len[i] : DIST_MAX;
            rep.reachable   = reached[i];
            rep.last        = (i == n - 1);
            pending_reports = {pending_reports, rep};
        end
    endtask

    always @(posedge clk)
    begin
        node_report_t want;
        if (!rst_n)
        begin
            pending_reports.delete();
            node_count_q    = COUNT_RESET;
            fail_count      = 0;
            reports_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_count_q = cfg_data;
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                begin
                    if (int'(row) < MAX_NODES && int'(col) < MAX_NODES)
                        edge_store[row][col] = weight;
                end
                else
                    predict_distances(source);
            end
            if (out_valid && out_ready)
            begin
                reports_checked++;
                if (pending_reports.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("MISMATCH: report for node %0d (distance %0d) arrived unexpected",
                                 node, distance);
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (want.node !== node || want.distance !== distance ||
                        want.reachable !== reachable || want.last !== last)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"MISMATCH: expected node %0d distance %0d reachable %0b",
                                      " last %0b, got node %0d distance %0d reachable %0b last %0b"},
                                     want.node, want.distance, want.reachable, want.last,
                                     node, distance, reachable, last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding  = pending_reports.size();
        nodes_in_use = active_count(node_count_q);
    end

endmodule

// ===== verif/tb_single_source_shortest_path_unit.sv =====
// ----------------------------------------------------------------------------
// tb_single_source_shortest_path_unit
// Stimulus and verdict for the shortest-path unit.
// ----------------------------------------------------------------------------
// Loads edge weights and issues runs under a sequence of node_count settings,
// with random gaps on the input and random back-pressure on the output. The
// checker beside the block predicts every node report and counts mismatches;
// this module only drives the block and decides the outcome.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_path_unit;
    import ssp_pkg::*;

    // The receiver's long hold-off must outlast a full sixteen-node run, so
    // that the block's input genuinely backs up behind the stalled results.
    localparam int HOLD_CYCLES   = 1200;
    // A load is written straight into the matrix store, so a short settle is
    // enough before a register write once the last expected report has been seen.
    localparam int SETTLE_CYCLES = 10;
    // The tail outlasts a full run, so it covers anything stray.
    localparam int TAIL_CYCLES   = 400;
    localparam int RUN_LIMIT     = 10000000;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 24;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   source;
    logic                out_valid;
    logic                out_ready;
    logic [NODE_W-1:0]   node;
    logic [DIST_W-1:0]   distance;
    logic                reachable;
    logic                last;

    int fail_count;
    int outstanding;
    int nodes_in_use;
    int reports_checked;

    // Which matrix entries hold a loaded weight. A run must never read one
    // that was not, so the active nodes' entries are filled before each random run.
    bit loaded [NODE_LIMIT][NODE_LIMIT];
    int loads_sent;
    int runs_sent;
    int settings_used;
    bit tx_burst;
    bit hold_request;
    bit hold_served;

    single_source_shortest_path_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .row       (row),
        .col       (col),
        .weight    (weight),
        .source    (source),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .node      (node),
        .distance  (distance),
        .reachable (reachable),
        .last      (last)
    );

    ssp_path_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .row             (row),
        .col             (col),
        .weight          (weight),
        .source          (source),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .node            (node),
        .distance        (distance),
        .reachable       (reachable),
        .last            (last),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .nodes_in_use    (nodes_in_use),
        .reports_checked (reports_checked)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Node-count settings for the random phases. They grow at first so that
    // the matrix is filled gradually, then revisit the extremes: zero acts as
    // one, and seventeen behaves like the full sixteen.
    function automatic logic [COUNT_W-1:0] phase_count(input int p);
        case (p)
            0:       return 5'd2;
            1:       return 5'd3;
            2:       return 5'd5;
            3:       return 5'd8;
            4:       return 5'd16;
            5:       return 5'd12;
            6:       return 5'd1;
            7:       return 5'd31;
            8:       return 5'd6;
            9:       return 5'd0;
            default: return 5'd17;
        endcase
    endfunction

    // Idle length between transfers: mostly none or short, now and then long.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Small weights make ties and long chains; the rest covers the boundary
    // just below the no-edge value and the whole range at or above it.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return WEIGHT_W'($urandom_range(0, 3));
        if (r < 60)
            return WEIGHT_W'($urandom_range(4, 60));
        if (r < 78)
            return NO_EDGE;
        if (r < 88)
            return WEIGHT_W'($urandom_range(10000, 16383));
        return WEIGHT_W'($urandom_range(9990, 9998));
    endfunction

    // Offers one item and returns once the transfer has taken place. Valid
    // is left high, so back-to-back items follow without a dip.
    task automatic push_item(input logic cmd, input logic [NODE_W-1:0] r,
                             input logic [NODE_W-1:0] c, input logic [WEIGHT_W-1:0] w,
                             input logic [NODE_W-1:0] src);
        int gap;
        gap = pick_gap(tx_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        row      = r;
        col      = c;
        weight   = w;
        source   = src;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_edge(input logic [NODE_W-1:0] r, input logic [NODE_W-1:0] c,
                             input logic [WEIGHT_W-1:0] w);
        loaded[r][c] = 1'b1;
        loads_sent++;
        push_item(CMD_LOAD, r, c, w, NODE_W'($urandom_range(0, 15)));
    endtask

    // The unused load fields are randomised on a run too.
    task automatic run_from(input logic [NODE_W-1:0] src);
        runs_sent++;
        push_item(CMD_RUN, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom_range(0, 15)),
                  pick_weight(), src);
    endtask

    // Loads every entry among the first n nodes that has not been loaded yet.
    task automatic complete_matrix(input int n);
        int r;
        int c;
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (!loaded[r][c])
                    load_edge(NODE_W'(r), NODE_W'(c), pick_weight());
    endtask

    // Stops offering and waits for every predicted report to arrive.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    // Output side: ready stretches of random length broken by random gaps.
    // On request it holds off for a long, counted stretch, once.
    initial
    begin
        int ready_left;
        int gap_left;
        out_ready   = 1'b0;
        hold_served = 1'b0;
        ready_left  = 0;
        gap_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            else if (gap_left > 0)
            begin
                out_ready = 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (ready_left > 0)
                    ready_left--;
                else
                begin
                    ready_left = $urandom_range(0, 23);
                    gap_left   = pick_gap(1'b0);
                end
            end
        end
    end

    // Input side and verdict.
    initial
    begin
        int p;
        int k;
        int n;
        int r;
        logic [NODE_W-1:0] src;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_LOAD;
        row           = '0;
        col           = '0;
        weight        = '0;
        source        = '0;
        tx_burst      = 1'b0;
        hold_request  = 1'b0;
        loads_sent    = 0;
        runs_sent     = 0;
        settings_used = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening under the reset node count of sixteen. Only row 0
        // is loaded: a zero-weight self loop, then no-edge weights that span
        // the bottom of the no-edge range up to the field maximum. Node 0 is
        // therefore the only reachable one, and no other row is ever read.
        for (k = 0; k < NODE_LIMIT; k++)
        begin
            if (k == 0)
                load_edge(NODE_W'(k), NODE_W'(k), '0);
            else if (k == 1)
                load_edge('0, NODE_W'(k), '1);
            else if (k == NODE_LIMIT - 1)
                load_edge('0, NODE_W'(k), 14'd10000);
            else
                load_edge('0, NODE_W'(k), NO_EDGE);
        end
        run_from('0);

        // A zero count acts as one node; a source beyond the active nodes
        // leaves every active node unreachable.
        drain_results();
        write_node_count(5'd0);
        run_from('0);
        run_from(4'd9);

        // The largest register value acts as sixteen nodes.
        drain_results();
        write_node_count(5'd31);
        run_from('0);

        // Random phases, each under its own node count. Loads are aimed mostly
        // at the active nodes so that the runs see real graphs.
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_node_count(phase_count(p));
            n        = nodes_in_use;
            tx_burst = (p % 3 == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    drain_results();
                else if (r < 68)
                begin
                    if ($urandom_range(0, 99) < 80)
                        load_edge(NODE_W'($urandom_range(0, n - 1)),
                                  NODE_W'($urandom_range(0, n - 1)), pick_weight());
                    else
                        load_edge(NODE_W'($urandom_range(0, 15)),
                                  NODE_W'($urandom_range(0, 15)), pick_weight());
                end
                else
                begin
                    complete_matrix(n);
                    // On the first full-size run early in its phase, the output holds
                    // off for a long while; the items that follow then pile up behind it.
                    if (!hold_request && n == NODE_LIMIT && k < PHASE_ITEMS - 6)
                        hold_request = 1'b1;
                    if (n < NODE_LIMIT && $urandom_range(0, 99) < 15)
                        src = NODE_W'($urandom_range(n, 15));
                    else
                        src = NODE_W'($urandom_range(0, n - 1));
                    run_from(src);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Covered %0d input transfers: %0d edge loads and %0d shortest-path runs.",
                 loads_sent + runs_sent, loads_sent, runs_sent);
        $display("Checked %0d node reports across %0d node-count settings.",
                 reports_checked, settings_used);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Safety net: a hung handshake ends the run here.
    initial
    begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
